[rtl/pfa_pkg.sv]
// Shared types and codes for the partition fit allocator.
`timescale 1ns / 1ps
package pfa_pkg;

	localparam int SIZE_W  = 32;
	localparam int LDIDX_W = 4;
	localparam int PCNT_W  = 5;
	localparam int PADDR_W = 3;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RESTORE = 2'd2,
		OP_NONE    = 2'd3
	} opcode_e_t;

	typedef enum logic [1:0] {
		FIT_BEST  = 2'd0,
		FIT_WORST = 2'd1,
		FIT_FIRST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_mode_e_t;

	// register index = paddr[2]
	localparam logic REG_FIT_MODE   = 1'b0;
	localparam logic REG_PART_COUNT = 1'b1;

	// broadcast to every cell during a scan
	typedef struct packed {
		fit_mode_e_t       mode;
		logic [SIZE_W-1:0] req;
	} scan_ctl_t;

	// broadcast table updates
	typedef struct packed {
		logic               ld_en;
		logic               rs_en;
		logic               cm_en;
		logic [LDIDX_W-1:0] ld_idx;
		logic [SIZE_W-1:0]  data;
	} upd_ctl_t;

endpackage

[rtl/pfa_cell.sv]
// One partition cell: holds its sizes and refines the candidate passed down the chain.
`timescale 1ns / 1ps
module pfa_cell import pfa_pkg::*; #(
	parameter int IDX_W    = 4,
	parameter int CNT_W    = 5,
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         scan,
	input  logic [IDX_W-1:0]  ptr,
	input  logic [CNT_W-1:0]  cnt,
	input  upd_ctl_t          upd,
	input  logic [IDX_W-1:0]  cm_idx,
	input  logic              tok_in,
	input  logic              found_in,
	input  logic [IDX_W-1:0]  idx_in,
	input  logic [SIZE_W-1:0] size_in,
	input  logic              lo_found_in,
	input  logic [IDX_W-1:0]  lo_idx_in,
	output logic              tok_q,
	output logic              found_q,
	output logic [IDX_W-1:0]  idx_q,
	output logic [SIZE_W-1:0] size_q,
	output logic              lo_found_q,
	output logic [IDX_W-1:0]  lo_idx_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] orig_q;
	logic              in_use;
	logic              take;
	logic              found_d;
	logic [IDX_W-1:0]  idx_d;
	logic [SIZE_W-1:0] size_d;
	logic              lo_found_d;
	logic [IDX_W-1:0]  lo_idx_d;

	assign in_use = CNT_W'(CELL_IDX) < cnt;
	assign take   = tok_in && in_use && (rem_q >= scan.req);

	always_comb begin
		found_d    = found_in;
		idx_d      = idx_in;
		size_d     = size_in;
		lo_found_d = lo_found_in;
		lo_idx_d   = lo_idx_in;
		case (scan.mode)
			FIT_BEST: begin
				if (take && (!found_in || rem_q < size_in)) begin
					found_d = 1'b1;
					idx_d   = MY_IDX;
					size_d  = rem_q;
				end
			end
			FIT_WORST: begin
				if (take && (!found_in || rem_q > size_in)) begin
					found_d = 1'b1;
					idx_d   = MY_IDX;
					size_d  = rem_q;
				end
			end
			FIT_FIRST: begin
				if (take && !found_in) begin
					found_d = 1'b1;
					idx_d   = MY_IDX;
					size_d  = rem_q;
				end
			end
			FIT_NEXT: begin
				// wrapped part of the circular pass collects in the lo slot
				if (take && MY_IDX >= ptr && !found_in) begin
					found_d = 1'b1;
					idx_d   = MY_IDX;
					size_d  = rem_q;
				end else if (take && MY_IDX < ptr && !lo_found_in) begin
					lo_found_d = 1'b1;
					lo_idx_d   = MY_IDX;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in) begin
			found_q    <= found_d;
			idx_q      <= idx_d;
			size_q     <= size_d;
			lo_found_q <= lo_found_d;
			lo_idx_q   <= lo_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.ld_en && {{(32-LDIDX_W){1'b0}}, upd.ld_idx} == 32'(CELL_IDX)) begin
			rem_q  <= upd.data;
			orig_q <= upd.data;
		end else if (upd.rs_en) begin
			rem_q <= orig_q;
		end else if (upd.cm_en && cm_idx == MY_IDX) begin
			rem_q <= rem_q - upd.data;
		end
	end

endmodule

[rtl/partition_fit_allocator.sv]
// Top level: control, configuration registers and the chain of partition cells.
`timescale 1ns / 1ps
// Fixed-partition allocator. Load, restore and unused-opcode words give no result.
// An allocate word's candidate walks the cell chain one cell per cycle, then the
// done state commits the subtraction and fills the output register; if that
// register still holds an untaken result, the commit waits for m_tready. A new word
// is accepted whenever no allocate is in flight, even while a result waits on the
// master side.
// Configuration (fit mode, partition count) must be written only while idle.
module partition_fit_allocator import pfa_pkg::*; #(
	parameter int MAX_PARTITIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [39:0]        s_tdata,   // [3:0] partition_index, [35:4] size_value, pad
	input  logic [1:0]         s_tuser,   // [1:0] opcode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [3:0] chosen_partition, pad
	output logic [0:0]         m_tuser,   // [0] granted
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int N     = MAX_PARTITIONS;
	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
	localparam int CNT_W = $clog2(N + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_e_t;

	state_e_t          state_q;
	fit_mode_e_t       fit_mode_q;
	logic [PCNT_W-1:0] pcount_q;
	logic [IDX_W-1:0]  next_ptr_q;
	logic [IDX_W-1:0]  scan_ptr_q;
	logic [SIZE_W-1:0] req_q;
	logic              start_q;
	logic              m_tvalid_q;
	logic              res_grant_q;
	logic [IDX_W-1:0]  res_idx_q;

	logic [CNT_W-1:0]  act_cnt;
	logic              in_acc;
	opcode_e_t         op;
	logic              cfg_wr;
	logic              out_load;
	logic              fin_grant;
	logic [IDX_W-1:0]  fin_idx;
	scan_ctl_t         scan;
	upd_ctl_t          upd;

	logic              tok      [N];
	logic              found    [N];
	logic [IDX_W-1:0]  idx      [N];
	logic [SIZE_W-1:0] size     [N];
	logic              lo_found [N];
	logic [IDX_W-1:0]  lo_idx   [N];

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign op       = opcode_e_t'(s_tuser);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, 4'(res_idx_q)};
	assign m_tuser  = res_grant_q;

	always_comb begin
		if (32'(pcount_q) > N) begin
			act_cnt = CNT_W'(N);
		end else begin
			act_cnt = CNT_W'(pcount_q);
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FIT_MODE:   prdata = {30'd0, fit_mode_q};
			REG_PART_COUNT: prdata = {{(32-PCNT_W){1'b0}}, pcount_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_BEST;
			pcount_q   <= PCNT_W'(16);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FIT_MODE:   fit_mode_q <= fit_mode_e_t'(pwdata[1:0]);
				REG_PART_COUNT: pcount_q   <= pwdata[PCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// final pick from the tail of the chain
	assign fin_grant = found[N-1] || lo_found[N-1];
	assign fin_idx   = found[N-1] ? idx[N-1] : (lo_found[N-1] ? lo_idx[N-1] : '0);
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign scan.mode = fit_mode_q;
	assign scan.req  = req_q;

	always_comb begin
		upd.ld_en  = in_acc && op == OP_LOAD;
		upd.rs_en  = in_acc && op == OP_RESTORE;
		upd.cm_en  = out_load && fin_grant;
		upd.ld_idx = s_tdata[3:0];
		upd.data   = upd.cm_en ? req_q : s_tdata[35:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			next_ptr_q  <= '0;
			m_tvalid_q  <= 1'b0;
			res_grant_q <= 1'b0;
			res_idx_q   <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && op == OP_ALLOC) begin
						start_q <= 1'b1;
						state_q <= ST_SCAN;
					end else if (in_acc && op == OP_RESTORE) begin
						next_ptr_q <= '0;
					end
				end
				ST_SCAN: begin
					if (tok[N-1]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (fin_grant) begin
							next_ptr_q <= fin_idx;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				m_tvalid_q  <= 1'b1;
				res_grant_q <= fin_grant;
				res_idx_q   <= fin_idx;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_ALLOC) begin
			req_q      <= s_tdata[35:4];
			// a stale pointer restarts the pass at partition zero
			scan_ptr_q <= (CNT_W'(next_ptr_q) < act_cnt) ? next_ptr_q : '0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		if (k == 0) begin : g_head
			pfa_cell #(.IDX_W(IDX_W), .CNT_W(CNT_W), .CELL_IDX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .scan(scan), .ptr(scan_ptr_q), .cnt(act_cnt),
				.upd(upd), .cm_idx(fin_idx),
				.tok_in(start_q), .found_in(1'b0), .idx_in('0), .size_in('0),
				.lo_found_in(1'b0), .lo_idx_in('0),
				.tok_q(tok[k]), .found_q(found[k]), .idx_q(idx[k]), .size_q(size[k]),
				.lo_found_q(lo_found[k]), .lo_idx_q(lo_idx[k])
			);
		end else begin : g_body
			pfa_cell #(.IDX_W(IDX_W), .CNT_W(CNT_W), .CELL_IDX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .scan(scan), .ptr(scan_ptr_q), .cnt(act_cnt),
				.upd(upd), .cm_idx(fin_idx),
				.tok_in(tok[k-1]), .found_in(found[k-1]), .idx_in(idx[k-1]),
				.size_in(size[k-1]), .lo_found_in(lo_found[k-1]), .lo_idx_in(lo_idx[k-1]),
				.tok_q(tok[k]), .found_q(found[k]), .idx_q(idx[k]), .size_q(size[k]),
				.lo_found_q(lo_found[k]), .lo_idx_q(lo_idx[k])
			);
		end
	end

	// the scan token sits in the chain only while scanning, and the tail token ends it
	a_tok_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[N-1] |-> state_q == ST_SCAN)
		else $error("scan token outside scan state");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_grant_q) |-> (CNT_W'(res_idx_q) < act_cnt))
		else $error("granted partition beyond count in use");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("finished allocate did not reach output register");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> ($past(state_q) == ST_IDLE && state_q == ST_SCAN))
		else $error("scan started outside idle");

endmodule
